### src/wstm_pkg.sv
`default_nettype none

package wstm_pkg;

    localparam int TEXT_BITS  = 8;
    localparam int LEN_BITS   = 4;
    localparam int TOTAL_BITS = 20;
    localparam int OUT_ROW_BITS = 20;
    localparam int OUT_COL_BITS = 16;
    localparam int CFG_DATA_BITS = 64;
    localparam int CFG_ADDR_BITS = 4;

    localparam logic [TEXT_BITS-1:0] CASE_OFFSET = 8'd32;  // 'a' - 'A'
    localparam logic [TEXT_BITS-1:0] CH_NEWLINE  = 8'h0A;
    localparam logic [TEXT_BITS-1:0] CH_TAB      = 8'h09;
    localparam logic [TEXT_BITS-1:0] CH_SPACE    = 8'h20;
    localparam logic [TEXT_BITS-1:0] CH_UPPER_A  = 8'h41;
    localparam logic [TEXT_BITS-1:0] CH_UPPER_Z  = 8'h5A;

    // register index codes (byte address bit 3)
    localparam logic REG_PATTERN_CHARS  = 1'b0;
    localparam logic REG_PATTERN_LENGTH = 1'b1;

    // result kinds
    localparam logic KIND_MATCH   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic [TEXT_BITS-1:0] text_byte;
        logic                 end_of_text;
    } in_item_t;

    typedef struct packed {
        logic                    result_kind;
        logic [OUT_ROW_BITS-1:0] match_row;
        logic [OUT_COL_BITS-1:0] match_column;
        logic [TOTAL_BITS-1:0]   match_total;
    } out_item_t;

    // per-cycle control broadcast to every cell
    typedef struct packed {
        logic advance;  // a non-whitespace byte moves through the chain
        logic clear;    // drop all pending candidates
    } cell_ctl_t;

    function automatic logic [TEXT_BITS-1:0] to_lower(input logic [TEXT_BITS-1:0] c);
        logic [TEXT_BITS-1:0] r;
        r = c;
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            r = c + CASE_OFFSET;
        end
        return r;
    endfunction

    function automatic logic is_blank(input logic [TEXT_BITS-1:0] c);
        return (c == CH_NEWLINE) || (c == CH_TAB) || (c == CH_SPACE);
    endfunction

endpackage

`default_nettype wire

### src/whitespace_skipping_text_matcher_top.sv
`default_nettype none

// Whitespace-skipping, case-insensitive pattern search over a byte stream.
//
// Input channel (s_*): one transfer carries one text byte, or an end-of-text
// marker. Bytes A-Z are folded to lower case; space, tab and newline inside a
// match are skipped. Overlapping matches are all reported.
// Output channel (m_*): a match result (row/column of the match start and the
// running total) when the last pattern character arrives, and a summary with
// the final total for every end-of-text transfer.
// Throughput: one byte per cycle while s_ready is high. Results are held in the
// output or skid register. Per-character comparison happens in a chain of
// MAX_PATTERN cells, each holding one partial match and passing it on.
// Output buffering is two deep (output register plus skid register), so the
// block keeps taking bytes while one result waits; s_ready drops only while
// both entries are full, i.e. when the receiver stalls for long.
// Reset (aresetn low, synchronous): position 1/1, total 0, no candidates,
// pattern 0, length 1. End of text returns position and total to reset
// values. APB: pattern_chars at 0x0, pattern_length at 0x8; any write drops
// pending candidates.
module whitespace_skipping_text_matcher_top
    import wstm_pkg::*;
#(
    parameter int MAX_PATTERN = 8,
    parameter int ROW_BITS    = 20,
    parameter int COLUMN_BITS = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    // text input
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire in_item_t                 s_data,
    // results
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output out_item_t                     m_data,
    // configuration
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [CFG_ADDR_BITS-1:0] paddr,
    input  wire logic [CFG_DATA_BITS-1:0] pwdata,
    output logic [CFG_DATA_BITS-1:0]      prdata,
    output logic                          pready
);

    // ---------------- configuration registers ----------------
    logic [CFG_DATA_BITS-1:0] pattern_reg;
    logic [LEN_BITS-1:0]      length_reg;
    logic                     cfg_wr;
    logic                     reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[3];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_reg <= '0;
            length_reg  <= LEN_BITS'(1);
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_PATTERN_CHARS:  pattern_reg <= pwdata;
                REG_PATTERN_LENGTH: length_reg  <= pwdata[LEN_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_PATTERN_CHARS:  prdata = pattern_reg;
            REG_PATTERN_LENGTH: prdata = {{(CFG_DATA_BITS-LEN_BITS){1'b0}}, length_reg};
            default:            prdata = '0;
        endcase
    end

    // length clamped to 1..MAX_PATTERN
    logic [LEN_BITS-1:0] len_eff;
    always_comb begin
        priority if (length_reg == '0) begin
            len_eff = LEN_BITS'(1);
        end else if (length_reg > LEN_BITS'(MAX_PATTERN)) begin
            len_eff = LEN_BITS'(MAX_PATTERN);
        end else begin
            len_eff = length_reg;
        end
    end

    // ---------------- input decode ----------------
    logic                 in_xfer;
    logic                 eot_xfer;
    logic                 byte_xfer;
    logic [TEXT_BITS-1:0] lc_byte;
    logic                 blank;

    assign in_xfer   = s_valid && s_ready;
    assign eot_xfer  = in_xfer && s_data.end_of_text;
    assign byte_xfer = in_xfer && !s_data.end_of_text;
    assign lc_byte   = to_lower(s_data.text_byte);
    assign blank     = is_blank(lc_byte);

    // ---------------- position and total ----------------
    logic [ROW_BITS-1:0]    row_reg, row_next;
    logic [COLUMN_BITS-1:0] col_reg, col_next;
    logic [TOTAL_BITS-1:0]  found_reg, found_next;
    logic [TOTAL_BITS-1:0]  found_inc;

    // ---------------- candidate chain ----------------
    cell_ctl_t              ctl;
    logic [MAX_PATTERN-1:0] cand_valid;
    logic [MAX_PATTERN-1:0] cell_hit;
    logic [MAX_PATTERN-1:0] left_valid;
    logic [ROW_BITS-1:0]    cand_row [MAX_PATTERN];
    logic [COLUMN_BITS-1:0] cand_col [MAX_PATTERN];
    logic [ROW_BITS-1:0]    left_row [MAX_PATTERN];
    logic [COLUMN_BITS-1:0] left_col [MAX_PATTERN];

    assign ctl.advance = byte_xfer && !blank;
    assign ctl.clear   = cfg_wr || eot_xfer;

    // cell 0 starts a candidate at the current position
    assign left_valid[0] = 1'b1;
    assign left_row[0]   = row_reg;
    assign left_col[0]   = col_reg;

    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
        if (k > 0) begin : g_link
            assign left_valid[k] = cand_valid[k-1];
            assign left_row[k]   = cand_row[k-1];
            assign left_col[k]   = cand_col[k-1];
        end

        wstm_cell #(
            .ROW_BITS    (ROW_BITS),
            .COLUMN_BITS (COLUMN_BITS)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctl        (ctl),
            .text_char  (lc_byte),
            .pat_char   (pattern_reg[TEXT_BITS*k +: TEXT_BITS]),
            .keep       ((LEN_BITS'(k) + LEN_BITS'(1)) < len_eff),
            .is_last    ((LEN_BITS'(k) + LEN_BITS'(1)) == len_eff),
            .left_valid (left_valid[k]),
            .left_row   (left_row[k]),
            .left_col   (left_col[k]),
            .valid      (cand_valid[k]),
            .row        (cand_row[k]),
            .col        (cand_col[k]),
            .hit        (cell_hit[k])
        );
    end

    // only the cell at the pattern end can hit, so an OR-mux suffices
    logic                   hit_any;
    logic [ROW_BITS-1:0]    hit_row;
    logic [COLUMN_BITS-1:0] hit_col;

    always_comb begin
        hit_row = '0;
        hit_col = '0;
        for (int k = 0; k < MAX_PATTERN; k++) begin
            hit_row = hit_row | (cell_hit[k] ? left_row[k] : '0);
            hit_col = hit_col | (cell_hit[k] ? left_col[k] : '0);
        end
    end

    assign hit_any   = |cell_hit;
    assign found_inc = (found_reg != '1) ? found_reg + TOTAL_BITS'(1) : found_reg;

    always_comb begin
        row_next   = row_reg;
        col_next   = col_reg;
        found_next = found_reg;
        if (eot_xfer) begin
            row_next   = ROW_BITS'(1);
            col_next   = COLUMN_BITS'(1);
            found_next = '0;
        end else if (byte_xfer) begin
            if (lc_byte == CH_NEWLINE) begin
                if (row_reg != '1) begin
                    row_next = row_reg + ROW_BITS'(1);
                end
                col_next = COLUMN_BITS'(1);
            end else if (col_reg != '1) begin
                col_next = col_reg + COLUMN_BITS'(1);
            end
            if (hit_any) begin
                found_next = found_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg   <= ROW_BITS'(1);
            col_reg   <= COLUMN_BITS'(1);
            found_reg <= '0;
        end else begin
            row_reg   <= row_next;
            col_reg   <= col_next;
            found_reg <= found_next;
        end
    end

    // ---------------- result assembly ----------------
    logic      res_valid;
    out_item_t res;

    assign res_valid = eot_xfer || (byte_xfer && hit_any);

    always_comb begin
        if (s_data.end_of_text) begin
            res.result_kind  = KIND_SUMMARY;
            res.match_row    = '0;
            res.match_column = '0;
            res.match_total  = found_reg;
        end else begin
            res.result_kind  = KIND_MATCH;
            res.match_row    = OUT_ROW_BITS'(hit_row);
            res.match_column = OUT_COL_BITS'(hit_col);
            res.match_total  = found_inc;
        end
    end

    // ---------------- two-entry output buffer ----------------
    logic      m_valid_reg, m_valid_next;
    out_item_t m_data_reg, m_data_next;
    logic      skid_valid_reg, skid_valid_next;
    out_item_t skid_data_reg, skid_data_next;
    logic      pop;

    assign pop     = m_valid_reg && m_ready;
    assign s_ready = !skid_valid_reg;

    always_comb begin
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            // no input transfer possible while the skid entry is full
            if (pop) begin
                m_data_next     = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (res_valid && (!m_valid_reg || pop)) begin
            m_valid_next = 1'b1;
            m_data_next  = res;
        end else if (res_valid) begin
            skid_valid_next = 1'b1;
            skid_data_next  = res;
        end else if (pop) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        m_data_reg    <= m_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ---------------- assertions ----------------
    // skid entry is only ever filled behind a held output entry
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid entry valid without output entry");

    // at most one cell completes the pattern per byte
    a_single_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(cell_hit))
        else $error("more than one cell hit");

    // end of text drops candidates and restarts position and total
    a_eot_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        eot_xfer |=> (cand_valid == '0) && (found_reg == '0)
                     && (row_reg == ROW_BITS'(1)) && (col_reg == COLUMN_BITS'(1)))
        else $error("state not restarted after end of text");

    // a configuration write drops every pending candidate
    a_cfg_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr |=> (cand_valid == '0))
        else $error("candidates survived a configuration write");

endmodule

`default_nettype wire

### src/wstm_cell.sv
`default_nettype none

// One candidate slot: holds the start position of a partial match.
module wstm_cell
    import wstm_pkg::*;
#(
    parameter int ROW_BITS    = 20,
    parameter int COLUMN_BITS = 16
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire cell_ctl_t              ctl,
    input  wire logic [TEXT_BITS-1:0]   text_char,
    input  wire logic [TEXT_BITS-1:0]   pat_char,
    input  wire logic                   keep,      // slot lies below the last one
    input  wire logic                   is_last,   // slot completes the pattern
    input  wire logic                   left_valid,
    input  wire logic [ROW_BITS-1:0]    left_row,
    input  wire logic [COLUMN_BITS-1:0] left_col,
    output logic                        valid,
    output logic [ROW_BITS-1:0]         row,
    output logic [COLUMN_BITS-1:0]      col,
    output logic                        hit
);

    logic                   valid_reg, valid_next;
    logic [ROW_BITS-1:0]    row_reg, row_next;
    logic [COLUMN_BITS-1:0] col_reg, col_next;
    logic                   match;

    assign match = left_valid && (text_char == pat_char);
    assign hit   = ctl.advance && match && is_last;

    always_comb begin
        valid_next = valid_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        if (ctl.clear) begin
            valid_next = 1'b0;
        end else if (ctl.advance) begin
            valid_next = match && keep;
            row_next   = left_row;
            col_next   = left_col;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        row_reg <= row_next;
        col_reg <= col_next;
    end

    assign valid = valid_reg;
    assign row   = row_reg;
    assign col   = col_reg;

endmodule

`default_nettype wire
